### sv/ims_pkg.sv
// ----------------------------------------------------------------------------
// ims_pkg : shared types and constants for the Ising spin update block
// Field widths, function codes, register indexes and the remainder step.
// ----------------------------------------------------------------------------
`default_nettype none

package ims_pkg;

  localparam int FUNC_W   = 2;
  localparam int SITE_W   = 10;
  localparam int ROW_W    = 10;
  localparam int CNT_W    = 11;
  localparam int PROB_W   = 32;
  localparam int SUM_W    = 4;
  localparam int ROW_IDX_W = $clog2(ROW_W);
  localparam int SPLIT    = SITE_W / 2;   // remainder steps done in stage 1

  localparam logic [FUNC_W-1:0] FUNC_WRITE  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_UPDATE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;

  localparam logic [1:0] REG_ROW_WIDTH   = 2'd0;
  localparam logic [1:0] REG_SITE_COUNT  = 2'd1;
  localparam logic [1:0] REG_ACCEPT_LOW  = 2'd2;
  localparam logic [1:0] REG_ACCEPT_HIGH = 2'd3;

  localparam logic [ROW_W-1:0]  RST_ROW_WIDTH   = 10'd32;
  localparam logic [CNT_W-1:0]  RST_SITE_COUNT  = 11'd1024;
  localparam logic [PROB_W-1:0] RST_ACCEPT_LOW  = 32'd737360000;
  localparam logic [PROB_W-1:0] RST_ACCEPT_HIGH = 32'd126580000;

  typedef struct packed {
    logic [CNT_W-1:0]  n_eff;       // site count after clamping
    logic [CNT_W-1:0]  stride;      // row width modulo n_eff
    logic [PROB_W-1:0] accept_low;
    logic [PROB_W-1:0] accept_high;
    logic              busy;        // stride still being worked out
  } cfg_t;

  // One restoring step of a remainder: shift in a bit, subtract n if it fits.
  // Needs r < n on entry; the result is again below n.
  function automatic logic [CNT_W-1:0] rem_step(input logic [CNT_W-1:0] r,
                                                input logic b,
                                                input logic [CNT_W-1:0] n);
    logic [CNT_W:0] t;
    t = {r, b};
    if (t >= {1'b0, n}) begin
      t = t - {1'b0, n};
    end
    return t[CNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

### sv/ims_ram.sv
// ----------------------------------------------------------------------------
// ims_ram : generic single-write, single-read RAM
// One write port, one read port with registered, enabled read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ims_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### sv/ims_cfg.sv
// ----------------------------------------------------------------------------
// ims_cfg : configuration registers and stride unit
// APB register file; works out row width modulo site count, a bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ims_cfg #(
  parameter int MAX_SITES = 1024
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output      logic [31:0]  prdata,
  output      logic         pready,
  output      ims_pkg::cfg_t cfg
);

  localparam int CW = ims_pkg::CNT_W;
  localparam int RW = ims_pkg::ROW_W;
  localparam int BW = ims_pkg::ROW_IDX_W;
  localparam logic [CW-1:0] N_CLAMP =
    (MAX_SITES >= (1 << CW)) ? {CW{1'b1}} : CW'(MAX_SITES);

  logic [RW-1:0] row_width;
  logic [CW-1:0] site_count;
  logic [31:0]   accept_low;
  logic [31:0]   accept_high;

  logic          busy;
  logic [BW-1:0] bit_idx;
  logic [CW-1:0] rem;

  logic [1:0]    reg_idx;
  logic          wr_en;
  logic [CW-1:0] n_eff;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    if (site_count == '0) begin
      n_eff = CW'(1);
    end else if (site_count > N_CLAMP) begin
      n_eff = N_CLAMP;
    end else begin
      n_eff = site_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width   <= ims_pkg::RST_ROW_WIDTH;
      site_count  <= ims_pkg::RST_SITE_COUNT;
      accept_low  <= ims_pkg::RST_ACCEPT_LOW;
      accept_high <= ims_pkg::RST_ACCEPT_HIGH;
      busy        <= 1'b1;
      bit_idx     <= BW'(RW - 1);
      rem         <= '0;
    end else begin
      if (wr_en) begin
        case (reg_idx)
          ims_pkg::REG_ROW_WIDTH:   row_width   <= pwdata[RW-1:0];
          ims_pkg::REG_SITE_COUNT:  site_count  <= pwdata[CW-1:0];
          ims_pkg::REG_ACCEPT_LOW:  accept_low  <= pwdata;
          ims_pkg::REG_ACCEPT_HIGH: accept_high <= pwdata;
          default: ;
        endcase
      end
      // restart the stride sweep whenever either input to it changes
      if (wr_en && (reg_idx == ims_pkg::REG_ROW_WIDTH ||
                    reg_idx == ims_pkg::REG_SITE_COUNT)) begin
        busy    <= 1'b1;
        bit_idx <= BW'(RW - 1);
        rem     <= '0;
      end else if (busy) begin
        rem <= ims_pkg::rem_step(rem, row_width[bit_idx], n_eff);
        if (bit_idx == '0) begin
          busy <= 1'b0;
        end else begin
          bit_idx <= bit_idx - BW'(1);
        end
      end
    end
  end

  always_comb begin
    case (reg_idx)
      ims_pkg::REG_ROW_WIDTH:   prdata = 32'(row_width);
      ims_pkg::REG_SITE_COUNT:  prdata = 32'(site_count);
      ims_pkg::REG_ACCEPT_LOW:  prdata = accept_low;
      ims_pkg::REG_ACCEPT_HIGH: prdata = accept_high;
      default:                  prdata = '0;
    endcase
  end

  assign cfg.n_eff       = n_eff;
  assign cfg.stride      = rem;
  assign cfg.accept_low  = accept_low;
  assign cfg.accept_high = accept_high;
  assign cfg.busy        = busy;

endmodule

`default_nettype wire

### sv/ising_metropolis_spin_update.sv
// Throughput: one transaction per cycle unless the result side stalls or a
//   sweep runs, set by the pipeline (stages 0 to 3 and the output register)
//   and the five spin RAM copies that each serve one of the five reads.
// Reset: a clearing sweep sets every spin up; upd_ready stays low
//   meanwhile. A write to row_width or site_count holds upd_ready low
//   while the stride is recomputed.
// ----------------------------------------------------------------------------
// ising_metropolis_spin_update : 2D Ising lattice, single-site Metropolis
// Helical periodic lattice of one-bit spins with write, read and update.
// ----------------------------------------------------------------------------
`default_nettype none

module ising_metropolis_spin_update #(
  parameter int MAX_SITES = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // configuration
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [3:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output      logic [31:0]          prdata,
  output      logic                 pready,
  // request channel
  input  wire logic                 upd_valid,
  output      logic                 upd_ready,
  input  wire logic [1:0]           func,
  input  wire logic [9:0]           site,
  input  wire logic                 spin_in,
  input  wire logic [31:0]          random_u,
  // result channel
  output      logic                 res_valid,
  input  wire logic                 res_ready,
  output      logic                 flipped,
  output      logic                 spin_out,
  output      logic signed [3:0]    local_sum
);

  localparam int AW = $clog2(MAX_SITES);
  localparam int CW = ims_pkg::CNT_W;
  localparam int FW = ims_pkg::FUNC_W;
  localparam int SW = ims_pkg::SITE_W;
  localparam int HS = ims_pkg::SPLIT;
  localparam int NPORT = 5;   // site itself, then +1, -1, +row, -row
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_SITES - 1);

  ims_pkg::cfg_t cfg;

  ims_cfg #(.MAX_SITES(MAX_SITES)) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // --------------------------------------------------------------------------
  // Clearing sweep after reset: every spin is written up, one site a cycle.
  // --------------------------------------------------------------------------
  logic          clearing;
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == LAST_ADDR) begin
        clearing <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage control. A stage takes a new item when it is empty or its item
  // moves on; the chain runs back from the output register.
  // --------------------------------------------------------------------------
  logic v0, v1, v2, v3;
  logic out_free, free3, free2, free1, free0, adv3;

  assign out_free  = !res_valid || res_ready;
  assign adv3      = v3 && out_free;
  assign free3     = !v3 || out_free;
  assign free2     = !v2 || free3;
  assign free1     = !v1 || free2;
  assign free0     = !v0 || free1;
  assign upd_ready = free0 && !clearing && !cfg.busy;

  // --------------------------------------------------------------------------
  // Stage 0: registered request. Both acceptance compares are settled here
  // so only two flags travel on instead of the random word.
  // --------------------------------------------------------------------------
  logic [FW-1:0] f0;
  logic [SW-1:0] s0;
  logic          si0, lo0, hi0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (free0) begin
      v0 <= upd_valid && upd_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (free0) begin
      f0  <= func;
      s0  <= site;
      si0 <= spin_in;
      lo0 <= random_u < cfg.accept_low;
      hi0 <= random_u < cfg.accept_high;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: site modulo site count, upper half of the remainder steps.
  // --------------------------------------------------------------------------
  logic [CW-1:0] r0_next;

  always_comb begin
    r0_next = '0;
    for (int i = 0; i < HS; i++) begin
      r0_next = ims_pkg::rem_step(r0_next, s0[SW-1-i], cfg.n_eff);
    end
  end

  logic [FW-1:0]   f1;
  logic [CW-1:0]   r1;
  logic [SW-HS-1:0] low1;
  logic            si1, lo1, hi1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (free1) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (free1) begin
      f1   <= f0;
      r1   <= r0_next;
      low1 <= s0[SW-HS-1:0];
      si1  <= si0;
      lo1  <= lo0;
      hi1  <= hi0;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: lower half of the remainder steps gives the reduced site.
  // --------------------------------------------------------------------------
  logic [CW-1:0] r1_next;

  always_comb begin
    r1_next = r1;
    for (int i = 0; i < SW - HS; i++) begin
      r1_next = ims_pkg::rem_step(r1_next, low1[SW-HS-1-i], cfg.n_eff);
    end
  end

  logic [FW-1:0] f2;
  logic [CW-1:0] st2;
  logic          si2, lo2, hi2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (free2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (free2) begin
      f2  <= f1;
      st2 <= r1_next;
      si2 <= si1;
      lo2 <= lo1;
      hi2 <= hi1;
    end
  end

  // Neighbour sites. Site and stride are both below n, so each wrap is a
  // single compare and add or subtract.
  logic [CW-1:0] nx, px, ny, py;
  logic [CW:0]   inc, up, dn;
  logic [AW-1:0] rd_addr [NPORT];

  always_comb begin
    inc = {1'b0, st2} + (CW+1)'(1);
    up  = {1'b0, st2} + {1'b0, cfg.stride};
    dn  = {1'b0, st2} + {1'b0, cfg.n_eff} - {1'b0, cfg.stride};
    nx  = (inc == {1'b0, cfg.n_eff}) ? '0 : inc[CW-1:0];
    px  = (st2 == '0) ? cfg.n_eff - CW'(1) : st2 - CW'(1);
    ny  = (up >= {1'b0, cfg.n_eff}) ? up[CW-1:0] - cfg.n_eff : up[CW-1:0];
    py  = (st2 >= cfg.stride) ? st2 - cfg.stride : dn[CW-1:0];
    rd_addr[0] = AW'(st2);
    rd_addr[1] = AW'(nx);
    rd_addr[2] = AW'(px);
    rd_addr[3] = AW'(ny);
    rd_addr[4] = AW'(py);
  end

  // --------------------------------------------------------------------------
  // Spin store: five copies written alike, one read port each. Read data
  // only moves when stage 3 takes a new item, so a stalled item keeps it.
  // --------------------------------------------------------------------------
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic          ram_wdata;
  logic          rd_spin [NPORT];

  for (genvar k = 0; k < NPORT; k++) begin : g_copy
    ims_ram #(.WIDTH(1), .DEPTH(MAX_SITES)) u_ram (
      .clk   (clk),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (free3),
      .raddr (rd_addr[k]),
      .rdata (rd_spin[k])
    );
  end

  // --------------------------------------------------------------------------
  // Stage 3: spins read, decision and write-back.
  // --------------------------------------------------------------------------
  logic [FW-1:0] f3;
  logic [AW-1:0] a3 [NPORT];
  logic          si3, lo3, hi3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (free3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (free3) begin
      f3  <= f2;
      a3  <= rd_addr;
      si3 <= si2;
      lo3 <= lo2;
      hi3 <= hi2;
    end
  end

  // Last write, kept for forwarding: the item ahead may have written a site
  // at the very edge that this item's reads were sampled.
  logic          lw_en;
  logic [AW-1:0] lw_addr;
  logic          lw_data;

  logic       spin [NPORT];
  logic [2:0] agree;
  logic       is_upd, is_wr, flip, wr_need, wr_bit, spin_res;
  logic signed [4:0] dd;

  always_comb begin
    for (int k = 0; k < NPORT; k++) begin
      spin[k] = (lw_en && lw_addr == a3[k]) ? lw_data : rd_spin[k];
    end
    // neighbours that match the centre: local sum is 2*agree - 4
    agree = '0;
    for (int k = 1; k < NPORT; k++) begin
      agree = agree + 3'(spin[k] == spin[0]);
    end
    dd      = $signed({1'b0, agree, 1'b0}) - 5'sd4;
    is_upd  = (f3 == ims_pkg::FUNC_UPDATE);
    is_wr   = (f3 == ims_pkg::FUNC_WRITE);
    flip    = is_upd && ((agree <= 3'd2) || (agree == 3'd3 && lo3) ||
                         (agree == 3'd4 && hi3));
    wr_need = is_wr || flip;
    wr_bit  = is_wr ? si3 : !spin[0];
    spin_res = wr_need ? wr_bit : spin[0];
  end

  assign ram_we    = clearing || (adv3 && wr_need);
  assign ram_waddr = clearing ? clr_addr : a3[0];
  assign ram_wdata = clearing ? 1'b1 : wr_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      lw_en <= 1'b0;
    end else if (adv3 && wr_need) begin
      lw_en <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3 && wr_need) begin
      lw_addr <= a3[0];
      lw_data <= wr_bit;
    end
  end

  // --------------------------------------------------------------------------
  // Output register: parts the result side from the pipeline.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_free) begin
      res_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      flipped   <= flip;
      spin_out  <= spin_res;
      local_sum <= is_upd ? dd[3:0] : 4'sd0;
    end
  end

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  a_site_reduced: assert property (@(posedge clk) disable iff (rst)
    v2 |-> (st2 < cfg.n_eff))
    else $error("reduced site not below site count");

  a_nbr_in_range: assert property (@(posedge clk) disable iff (rst)
    v3 |-> (32'(a3[1]) < 32'(cfg.n_eff)) && (32'(a3[2]) < 32'(cfg.n_eff)) &&
           (32'(a3[3]) < 32'(cfg.n_eff)) && (32'(a3[4]) < 32'(cfg.n_eff)))
    else $error("neighbour site out of range");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (v3 && !out_free) |=> (v3 && $stable(a3[0]) && $stable(f3)))
    else $error("stalled item in decision stage changed");

  a_no_write_in_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !v3)
    else $error("item in flight during clearing sweep");

  a_clear_done_stays: assert property (@(posedge clk) disable iff (rst)
    !clearing |=> !clearing)
    else $error("clearing sweep restarted without reset");

endmodule

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top : testbench for ising_metropolis_spin_update
// Opens with a directed table of spin transactions, then runs random
// transactions under several lattice settings. Each result is checked
// against its typed table value, else a local lattice and register copy.
// ----------------------------------------------------------------------------

module tb_top;

  // func code 3 has no name in the package; the block treats it as a read
  localparam logic [ims_pkg::FUNC_W-1:0] FUNC_SPARE = 2'd3;
  localparam int LATTICE_MAX = 1024;
  localparam int IDLE_PCT    = 17;    // per-cycle chance of a bubble or stall

  typedef struct packed {
    logic                             flipped;
    logic                             spin;
    logic signed [ims_pkg::SUM_W-1:0] sum;
  } spin_result_t;

  // one row of the opening table; want is used only where typed is set
  typedef struct packed {
    logic [ims_pkg::FUNC_W-1:0] func;
    logic [ims_pkg::SITE_W-1:0] site;
    logic                       spin;
    logic [ims_pkg::PROB_W-1:0] rnd;
    logic                       typed;
    spin_result_t               want;
  } script_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [3:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               upd_valid = 1'b0;
  logic               upd_ready;
  logic [1:0]         func = '0;
  logic [9:0]         site = '0;
  logic               spin_in = 1'b0;
  logic [31:0]        random_u = '0;
  logic               res_valid;
  logic               res_ready = 1'b0;
  logic               flipped;
  logic               spin_out;
  logic signed [3:0]  local_sum;

  ising_metropolis_spin_update #(.MAX_SITES(LATTICE_MAX)) dut (.*);

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---- predicted block state --------------------------------------------
  bit                         lattice [LATTICE_MAX];
  logic [ims_pkg::ROW_W-1:0]  row_width_q;
  logic [ims_pkg::CNT_W-1:0]  site_count_q;
  logic [ims_pkg::PROB_W-1:0] accept_low_q;
  logic [ims_pkg::PROB_W-1:0] accept_high_q;

  spin_result_t pending_results [$];
  int           mismatch_count = 0;
  bit           calm = 1'b0;     // set: neither side idles

  // Directed opening, run with the reset settings (row 32, 1024 sites).
  // Covers reset contents, both wrap edges, the strict threshold at both
  // sums, negative and zero sums, and the spare func code.
  script_row_t opening_rows [23] = '{
    '{ims_pkg::FUNC_READ,   10'd0,    1'b0, 32'd0,
      1'b1, '{1'b0, 1'b1,  4'sd0}},
    '{ims_pkg::FUNC_READ,   10'd1023, 1'b1, 32'hFFFF_FFFF,
      1'b1, '{1'b0, 1'b1,  4'sd0}},
    '{FUNC_SPARE,           10'd7,    1'b0, 32'd0,
      1'b1, '{1'b0, 1'b1,  4'sd0}},
    '{ims_pkg::FUNC_UPDATE, 10'd5,    1'b0, 32'hFFFF_FFFF,
      1'b1, '{1'b0, 1'b1,  4'sd4}},
    '{ims_pkg::FUNC_UPDATE, 10'd5,    1'b1, 32'd0,
      1'b1, '{1'b1, 1'b0,  4'sd4}},
    '{ims_pkg::FUNC_UPDATE, 10'd5,    1'b0, 32'd0,
      1'b1, '{1'b1, 1'b1, -4'sd4}},
    '{ims_pkg::FUNC_WRITE,  10'd100,  1'b0, 32'hFFFF_FFFF,
      1'b1, '{1'b0, 1'b0,  4'sd0}},
    '{ims_pkg::FUNC_READ,   10'd100,  1'b1, 32'd0,
      1'b1, '{1'b0, 1'b0,  4'sd0}},
    '{ims_pkg::FUNC_UPDATE, 10'd101,  1'b0, 32'hFFFF_FFFF,
      1'b1, '{1'b0, 1'b1,  4'sd2}},
    '{ims_pkg::FUNC_UPDATE, 10'd101,  1'b1, 32'd0,
      1'b1, '{1'b1, 1'b0,  4'sd2}},
    '{ims_pkg::FUNC_UPDATE, 10'd101,  1'b0, 32'hFFFF_FFFF,
      1'b1, '{1'b1, 1'b1, -4'sd2}},
    '{ims_pkg::FUNC_UPDATE, 10'd101,  1'b0, ims_pkg::RST_ACCEPT_LOW,
      1'b1, '{1'b0, 1'b1,  4'sd2}},
    '{ims_pkg::FUNC_UPDATE, 10'd101,  1'b1, ims_pkg::RST_ACCEPT_LOW - 1,
      1'b1, '{1'b1, 1'b0,  4'sd2}},
    '{ims_pkg::FUNC_WRITE,  10'd1,    1'b0, 32'd0,
      1'b1, '{1'b0, 1'b0,  4'sd0}},
    '{ims_pkg::FUNC_WRITE,  10'd1023, 1'b0, 32'h5A5A_5A5A,
      1'b1, '{1'b0, 1'b0,  4'sd0}},
    '{ims_pkg::FUNC_UPDATE, 10'd0,    1'b1, 32'hFFFF_FFFF,
      1'b1, '{1'b1, 1'b0,  4'sd0}},
    '{ims_pkg::FUNC_READ,   10'd0,    1'b0, 32'd0,
      1'b1, '{1'b0, 1'b0,  4'sd0}},
    '{ims_pkg::FUNC_UPDATE, 10'd500,  1'b0, ims_pkg::RST_ACCEPT_HIGH,
      1'b1, '{1'b0, 1'b1,  4'sd4}},
    '{ims_pkg::FUNC_UPDATE, 10'd500,  1'b1, ims_pkg::RST_ACCEPT_HIGH - 1,
      1'b1, '{1'b1, 1'b0,  4'sd4}},
    '{ims_pkg::FUNC_UPDATE, 10'd1023, 1'b0, 32'hFFFF_FFFF,
      1'b0, '{1'b0, 1'b0,  4'sd0}},
    '{ims_pkg::FUNC_WRITE,  10'd1023, 1'b1, 32'hA5A5_A5A5,
      1'b1, '{1'b0, 1'b1,  4'sd0}},
    '{FUNC_SPARE,           10'd100,  1'b1, 32'hFFFF_FFFF,
      1'b1, '{1'b0, 1'b0,  4'sd0}},
    '{ims_pkg::FUNC_UPDATE, 10'd100,  1'b0, 32'h8000_0000,
      1'b0, '{1'b0, 1'b0,  4'sd0}}
  };

  // sites in use after clamping
  function automatic int unsigned live_sites();
    if (site_count_q == 0) return 1;
    if (site_count_q > LATTICE_MAX) return LATTICE_MAX;
    return site_count_q;
  endfunction

  // Applies one transaction to the local lattice and returns its result.
  // Sum d = spin(s) * (sum of the four helical neighbours); flip when d <= 0,
  // else when random_u is strictly below the threshold for d.
  function automatic spin_result_t metropolis_predict(
      input logic [ims_pkg::FUNC_W-1:0] f,
      input logic [ims_pkg::SITE_W-1:0] st,
      input logic                       sp,
      input logic [ims_pkg::PROB_W-1:0] ru);
    int unsigned  n, s, w, ups;
    int           nb, d;
    bit           flip;
    spin_result_t r;
    n = live_sites();
    s = st % n;
    r = '0;
    case (f)
      ims_pkg::FUNC_WRITE: lattice[s] = sp;
      ims_pkg::FUNC_UPDATE: begin
        w   = row_width_q % n;
        ups = lattice[(s + 1) % n] + lattice[(s + n - 1) % n]
            + lattice[(s + w) % n] + lattice[(s + n - w) % n];
        nb  = 2 * int'(ups) - 4;
        d   = lattice[s] ? nb : -nb;
        if (d <= 0) flip = 1'b1;
        else if (d == 2) flip = (ru < accept_low_q);
        else flip = (ru < accept_high_q);
        if (flip) lattice[s] = !lattice[s];
        r.flipped = flip;
        r.sum     = ims_pkg::SUM_W'(d);
      end
      default: ;   // read and the spare code leave the lattice alone
    endcase
    r.spin = lattice[s];
    return r;
  endfunction

  // ---- request side -----------------------------------------------------
  // Payload changes at the falling edge; acceptance is seen at the rising
  // edge. Valid is left high after acceptance so back-to-back transactions
  // need no second assignment in one step.
  task automatic send_item(input logic [ims_pkg::FUNC_W-1:0] f,
                           input logic [ims_pkg::SITE_W-1:0] st,
                           input logic sp, input logic [ims_pkg::PROB_W-1:0] ru,
                           input logic typed, input spin_result_t want);
    spin_result_t got;
    if (!calm) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        @(negedge clk);
        upd_valid <= 1'b0;
      end
    end
    @(negedge clk);
    upd_valid <= 1'b1;
    func      <= f;
    site      <= st;
    spin_in   <= sp;
    random_u  <= ru;
    do @(posedge clk); while (!upd_ready);
    got = metropolis_predict(f, st, sp, ru);
    pending_results.insert(pending_results.size(), typed ? want : got);
  endtask

  // Drops valid, waits until every result is back and lets the pipe settle.
  task automatic drain_lattice();
    @(negedge clk);
    upd_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // APB write: setup cycle, access cycle; upper bits of pwdata are junk so
  // the block must mask them.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      ims_pkg::REG_ROW_WIDTH:   row_width_q   = val[ims_pkg::ROW_W-1:0];
      ims_pkg::REG_SITE_COUNT:  site_count_q  = val[ims_pkg::CNT_W-1:0];
      ims_pkg::REG_ACCEPT_LOW:  accept_low_q  = val;
      ims_pkg::REG_ACCEPT_HIGH: accept_high_q = val;
      default: ;
    endcase
  endtask

  // Mostly updates on in-range sites so the lattice drifts into mixed
  // states; thresholds are hit exactly, just below and just above.
  task automatic random_items(input int count);
    int unsigned                n;
    int                         pick;
    logic [ims_pkg::FUNC_W-1:0] f;
    logic [ims_pkg::SITE_W-1:0] st;
    logic [ims_pkg::PROB_W-1:0] ru;
    n = live_sites();
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 60) f = ims_pkg::FUNC_UPDATE;
      else if (pick < 82) f = ims_pkg::FUNC_WRITE;
      else if (pick < 95) f = ims_pkg::FUNC_READ;
      else f = FUNC_SPARE;
      if ($urandom_range(9) == 0) st = ims_pkg::SITE_W'($urandom);
      else st = ims_pkg::SITE_W'($urandom_range(n - 1));
      case ($urandom_range(4))
        0: ru = accept_low_q + $urandom_range(2) - 1;
        1: ru = accept_high_q + $urandom_range(2) - 1;
        2: ru = $urandom_range(1) ? '1 : '0;
        default: ru = $urandom;
      endcase
      send_item(f, st, 1'($urandom), ru, 1'b0, '0);
    end
  endtask

  // one lattice setting followed by a burst of random transactions
  task automatic run_phase(input logic [ims_pkg::ROW_W-1:0] row,
                           input logic [ims_pkg::CNT_W-1:0] cnt,
                           input logic [ims_pkg::PROB_W-1:0] lo,
                           input logic [ims_pkg::PROB_W-1:0] hi,
                           input int count);
    drain_lattice();
    write_reg(ims_pkg::REG_ROW_WIDTH, ($urandom & ~32'h3FF) | 32'(row));
    write_reg(ims_pkg::REG_SITE_COUNT, ($urandom & ~32'h7FF) | 32'(cnt));
    write_reg(ims_pkg::REG_ACCEPT_LOW, lo);
    write_reg(ims_pkg::REG_ACCEPT_HIGH, hi);
    random_items(count);
  endtask

  // ---- result side ------------------------------------------------------
  always @(negedge clk) begin
    res_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    spin_result_t seen;
    spin_result_t want;
    if (!rst && res_valid && res_ready) begin
      seen = {flipped, spin_out, local_sum};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result transaction flipped=%b spin=%b sum=%0d",
                 $time, flipped, spin_out, local_sum);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (seen !== want) begin
          $display("%0t: mismatch exp flipped=%b spin=%b sum=%0d, got %b %b %0d",
                   $time, want.flipped, want.spin, want.sum,
                   seen.flipped, seen.spin, seen.sum);
          mismatch_count++;
        end
      end
    end
  end

  // ---- sequence ---------------------------------------------------------
  initial begin
    foreach (lattice[i]) lattice[i] = 1'b1;
    row_width_q   = ims_pkg::RST_ROW_WIDTH;
    site_count_q  = ims_pkg::RST_SITE_COUNT;
    accept_low_q  = ims_pkg::RST_ACCEPT_LOW;
    accept_high_q = ims_pkg::RST_ACCEPT_HIGH;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // the clearing sweep after reset shows as upd_ready low; send_item waits
    foreach (opening_rows[i]) begin
      send_item(opening_rows[i].func, opening_rows[i].site, opening_rows[i].spin,
                opening_rows[i].rnd, opening_rows[i].typed, opening_rows[i].want);
    end

    // four-site lattice, d > 0 never flips
    run_phase(10'd2, 11'd4, 32'd0, 32'd0, 100);
    // stride of half the lattice, always flips bar the all-ones draw
    run_phase(10'd512, 11'd1024, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 100);
    // zero sites read as one: every neighbour is the site itself
    run_phase(10'd0, 11'd0, 32'h8000_0000, 32'h4000_0000, 60);
    // count above the store is clamped, stride one below the clamped count
    run_phase(10'h3FF, 11'h7FF, ims_pkg::RST_ACCEPT_LOW, ims_pkg::RST_ACCEPT_HIGH, 100);
    // stride equal to count reduces to zero
    run_phase(10'd5, 11'd5, $urandom, $urandom, 100);
    // back-to-back stretch with no bubbles and no stalls
    calm = 1'b1;
    run_phase(10'd7, 11'd60, 32'h6000_0000, 32'h2000_0000, 150);
    calm = 1'b0;
    run_phase(ims_pkg::RST_ROW_WIDTH, ims_pkg::RST_SITE_COUNT,
              ims_pkg::RST_ACCEPT_LOW, ims_pkg::RST_ACCEPT_HIGH, 150);
    run_phase(10'd3, 11'd13, $urandom, $urandom, 120);

    drain_lattice();
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
